// ===== hdl/isfp_pkg.sv =====
// Shared types and constants for the IMU serial frame parser.
// No dependencies; imported by every module of the block.
package isfp_pkg;

	localparam int unsigned FRAME_LEN_DEF = 11;

	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam logic [7:0] TYPE_LO  = 8'h50;
	localparam logic [7:0] TYPE_HI  = 8'h5A;
	localparam logic [7:0] TYPE_ACC = 8'h51;
	localparam logic [7:0] TYPE_GYR = 8'h52;
	localparam logic [7:0] TYPE_ANG = 8'h53;

	// Payload bytes that feed a record: type at 1, data at 2..9
	localparam int unsigned STORE_FIRST = 1;
	localparam int unsigned STORE_LAST  = 9;

	typedef enum logic [1:0] {
		KIND_ACC = 2'd0,
		KIND_GYR = 2'd1,
		KIND_ANG = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]         record_kind;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [15:0] temperature;
	} record_t;

endpackage

// ===== hdl/imu_serial_frame_parser.sv =====
// Top level of the IMU serial frame parser.
// Depends on isfp_pkg, isfp_parser and isfp_out_skid.
//
// Input channel: one received UART byte per beat on rx_byte (in_valid/in_ready).
// The parser hunts for header 0x55, checks a type byte 0x50..0x5A, collects
// FRAME_LEN bytes and compares the last one against the 8-bit sum of the rest.
// Output channel: one record beat (out_valid/out_ready) for each good frame of
// type 0x51 (kind 0, with temperature), 0x52 (kind 1) or 0x53 (kind 2); the
// axes are little-endian signed 16-bit counts, temperature zero if not accel.
// Throughput: one byte per cycle while in_ready is high; every byte is handled
// in the cycle it is taken by the position/sum registers, with no iteration.
// Record path: a good record is pushed when its final byte is accepted and goes
// to the result register, or to the skid entry while that register is full.
// Stall: a result register plus one skid entry sit on the output; in_ready
// drops only while both are full, so bytes keep flowing during a short stall.
// Reset: arst_n clears the position (hunting for header), the sum and both
// output entries; no record is pending after reset.
module imu_serial_frame_parser #(
	parameter int unsigned FRAME_LEN = isfp_pkg::FRAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_kind,
	output logic signed [15:0] axis_x,
	output logic signed [15:0] axis_y,
	output logic signed [15:0] axis_z,
	output logic signed [15:0] temperature
);
	import isfp_pkg::*;

	logic    take;
	logic    rec_push;
	record_t rec;
	record_t out_rec;

	assign take = in_valid && in_ready;

	isfp_parser #(
		.FRAME_LEN(FRAME_LEN)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.rec_push(rec_push),
		.rec     (rec)
	);

	isfp_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rec_push),
		.push_rec (rec),
		.can_take (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rec  (out_rec)
	);

	assign record_kind = out_rec.record_kind;
	assign axis_x      = out_rec.axis_x;
	assign axis_y      = out_rec.axis_y;
	assign axis_z      = out_rec.axis_z;
	assign temperature = out_rec.temperature;

endmodule

// ===== hdl/isfp_parser.sv =====
// Byte-level frame parser: header hunt, type check, running sum, byte store.
// Depends on isfp_pkg; pushes a record for a good 0x51, 0x52 or 0x53 frame.
module isfp_parser #(
	parameter int unsigned FRAME_LEN = isfp_pkg::FRAME_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	output logic              rec_push,
	output isfp_pkg::record_t rec
);
	import isfp_pkg::*;

	localparam int unsigned PW = $clog2(FRAME_LEN);
	localparam logic [PW-1:0] POS_FINAL = PW'(FRAME_LEN - 1);

	logic [PW-1:0] pos_q;
	logic [7:0]    sum_q;
	logic [7:0]    store_q [STORE_FIRST:STORE_LAST];

	logic [PW-1:0] pos_d;
	logic [7:0]    sum_d;
	logic          is_hdr;
	logic          type_ok;
	logic          good_frame;
	logic [7:0]    kind_byte;

	assign is_hdr  = (rx_byte == HDR_BYTE);
	assign type_ok = (rx_byte inside {[TYPE_LO:TYPE_HI]});

	// Next position and sum for the byte on the input
	always_comb begin
		pos_d      = pos_q;
		sum_d      = sum_q;
		good_frame = 1'b0;
		if (pos_q == '0) begin
			if (is_hdr) begin
				pos_d = PW'(1);
				sum_d = rx_byte;
			end
		end else if (pos_q == PW'(1) && !type_ok) begin
			pos_d = is_hdr ? PW'(1) : '0;
			sum_d = rx_byte;
		end else if (pos_q < POS_FINAL) begin
			pos_d = pos_q + PW'(1);
			sum_d = sum_q + rx_byte;
		end else if (rx_byte != sum_q) begin
			// bad checksum: a header byte restarts the frame
			pos_d = is_hdr ? PW'(1) : '0;
			sum_d = rx_byte;
		end else begin
			pos_d      = '0;
			good_frame = 1'b1;
		end
	end

	// Hold position and sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (take) begin
			pos_q <= pos_d;
			sum_q <= sum_d;
		end
	end

	// Capture payload bytes at their fixed slots
	always_ff @(posedge clk) begin
		for (int i = STORE_FIRST; i <= STORE_LAST; i++) begin
			if (take && pos_q == PW'(i) && pos_q < POS_FINAL)
				store_q[i] <= rx_byte;
		end
	end

	// Build the record from the stored bytes
	assign kind_byte = store_q[1] - TYPE_ACC;

	always_comb begin
		rec.record_kind = kind_byte[1:0];
		rec.axis_x      = {store_q[3], store_q[2]};
		rec.axis_y      = {store_q[5], store_q[4]};
		rec.axis_z      = {store_q[7], store_q[6]};
		rec.temperature = (store_q[1] == TYPE_ACC) ? {store_q[9], store_q[8]} : 16'sd0;
	end

	assign rec_push = take && good_frame &&
		(store_q[1] == TYPE_ACC || store_q[1] == TYPE_GYR || store_q[1] == TYPE_ANG);

endmodule

// ===== hdl/isfp_out_skid.sv =====
// Result register with one skid entry behind it.
// Depends on isfp_pkg for the record type.
module isfp_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  isfp_pkg::record_t push_rec,
	output logic              can_take,
	output logic              out_valid,
	input  logic              out_ready,
	output isfp_pkg::record_t out_rec
);
	import isfp_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	record_t out_q;
	record_t skid_q;
	logic    pop;

	assign pop       = out_valid_q && out_ready;
	assign can_take  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_rec   = out_q;

	// Track occupancy of result and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= push;
		end else if (push) begin
			if (out_valid_q)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end
	end

	// Move payload: advance skid on drain, park new beat when stalled
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= push_rec;
		end else if (push) begin
			if (out_valid_q)
				skid_q <= push_rec;
			else
				out_q <= push_rec;
		end
	end

endmodule

// ===== hdl/isfp_checker.sv =====
// Port-level checks for imu_serial_frame_parser, bound to the top level.
// Depends on isfp_pkg for record kind codes.
module isfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  record_kind,
	input logic [15:0] axis_x,
	input logic [15:0] temperature
);
	import isfp_pkg::*;

	// Hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(record_kind) && $stable(axis_x))
		else $error("result beat changed while stalled");

	// Emit only the three defined kinds
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (record_kind == KIND_ACC || record_kind == KIND_GYR ||
			record_kind == KIND_ANG))
		else $error("undefined record kind");

	// Drop temperature for non-accel records
	a_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind != KIND_ACC |-> temperature == 16'd0)
		else $error("temperature set on non-accel record");

	// Backpressure only with a result pending
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind imu_serial_frame_parser isfp_checker u_isfp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.record_kind(record_kind),
	.axis_x     (axis_x),
	.temperature(temperature)
);

// ===== dv/imu_serial_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// Testbench for imu_serial_frame_parser: byte-stream stimulus, a cycle-free frame
// predictor and a record checker. Depends on isfp_pkg and the parser RTL only.
module imu_serial_frame_parser_tb;
	import isfp_pkg::*;

	localparam int FRAME_LEN   = FRAME_LEN_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_BYTES = 405;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        rx_byte = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [1:0]        record_kind;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic signed [15:0] temperature;

	// predictor state: frame position, running checksum, captured bytes
	logic [3:0]  parse_pos = 4'd0;
	logic [7:0]  parse_sum = 8'h00;
	logic [7:0]  parse_store [FRAME_LEN-1];
	record_t     pending_records [$];

	logic [7:0]  frame_buf [FRAME_LEN];
	int          gap_pct = 0;
	int          stall_pct = 0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          error_count = 0;
	int          frame_bytes_sent = 0;

	imu_serial_frame_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.record_kind (record_kind),
		.axis_x      (axis_x),
		.axis_y      (axis_y),
		.axis_z      (axis_z),
		.temperature (temperature)
	);

	always #6 clk = ~clk;

	// Track one accepted byte through the frame grammar; queue a record on a good frame
	function automatic void predict_record(input logic [7:0] b);
		record_t    rec;
		logic [7:0] ftype;
		if (parse_pos == 4'd0) begin
			if (b == HDR_BYTE) begin
				parse_store[0] = b;
				parse_sum = b;
				parse_pos = 4'd1;
			end
		end else if (parse_pos == 4'd1 && (b < TYPE_LO || b > TYPE_HI)) begin
			if (b == HDR_BYTE) begin
				parse_store[0] = b;
				parse_sum = b;
				parse_pos = 4'd1;
			end else begin
				parse_pos = 4'd0;
			end
		end else if (parse_pos < FRAME_LEN - 1) begin
			parse_store[parse_pos] = b;
			parse_sum = parse_sum + b;
			parse_pos = parse_pos + 4'd1;
		end else if (b != parse_sum) begin
			// bad checksum: a header byte opens the next frame
			if (b == HDR_BYTE) begin
				parse_store[0] = b;
				parse_sum = b;
				parse_pos = 4'd1;
			end else begin
				parse_pos = 4'd0;
			end
		end else begin
			parse_pos = 4'd0;
			ftype = parse_store[1];
			if (ftype == TYPE_ACC || ftype == TYPE_GYR || ftype == TYPE_ANG) begin
				case (ftype)
					TYPE_ACC: rec.record_kind = KIND_ACC;
					TYPE_GYR: rec.record_kind = KIND_GYR;
					default:  rec.record_kind = KIND_ANG;
				endcase
				rec.axis_x = {parse_store[3], parse_store[2]};
				rec.axis_y = {parse_store[5], parse_store[4]};
				rec.axis_z = {parse_store[7], parse_store[6]};
				rec.temperature = (ftype == TYPE_ACC) ? {parse_store[9], parse_store[8]} : 16'sd0;
				pending_records.push_back(rec);
			end
		end
	endfunction

	task automatic compare_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
		end
	endtask

	// Sample both channels at the rising edge: predict on input beats, check output beats
	always @(posedge clk) begin
		record_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_record(rx_byte);
			if (out_valid && out_ready) begin
				if (pending_records.size() == 0) begin
					error_count++;
					$display("%0t ns: unexpected record, expected none, actual kind %0d x %h y %h z %h t %h",
						$time, record_kind, axis_x, axis_y, axis_z, temperature);
				end else begin
					want = pending_records.pop_front();
					compare_field("record_kind", 16'(want.record_kind), 16'(record_kind));
					compare_field("axis_x", want.axis_x, axis_x);
					compare_field("axis_y", want.axis_y, axis_y);
					compare_field("axis_z", want.axis_z, axis_z);
					compare_field("temperature", want.temperature, temperature);
				end
			end
		end
	end

	// Count cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t ns: no beat for %0d cycles", $time, QUIET_LIMIT);
		$display("imu_serial_frame_parser_tb: errors");
		$finish;
	end

	// Drive out_ready: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one byte, with random gaps ahead of it, and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Close the input and wait for every queued record
	task automatic drain_records();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_records.size() != 0)
			@(posedge clk);
	endtask

	// Fill frame_buf with a frame of the given type and words, checksum included
	task automatic load_frame(input logic [7:0] ftype, input logic [15:0] w0,
			input logic [15:0] w1, input logic [15:0] w2, input logic [15:0] w3);
		logic [7:0] sum;
		frame_buf[0] = HDR_BYTE;
		frame_buf[1] = ftype;
		{frame_buf[3], frame_buf[2]} = w0;
		{frame_buf[5], frame_buf[4]} = w1;
		{frame_buf[7], frame_buf[6]} = w2;
		{frame_buf[9], frame_buf[8]} = w3;
		for (int i = 10; i < FRAME_LEN - 1; i++)
			frame_buf[i] = 8'h00;
		sum = 8'h00;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			sum = sum + frame_buf[i];
		frame_buf[FRAME_LEN-1] = sum;
	endtask

	task automatic send_frame_buf(input int first, input int count);
		for (int i = first; i < first + count; i++) begin
			send_byte(frame_buf[i]);
			frame_bytes_sent++;
		end
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Well-formed frame with random content; now and then a wrong checksum
	task automatic send_random_frame();
		logic [7:0] ftype;
		int         r;
		if ($urandom_range(99) < 80)
			ftype = TYPE_ACC + 8'($urandom_range(2));
		else
			ftype = 8'($urandom_range(TYPE_HI, TYPE_LO));
		load_frame(ftype, rand_word(), rand_word(), rand_word(), rand_word());
		r = $urandom_range(99);
		if (r < 6)
			frame_buf[FRAME_LEN-1] = HDR_BYTE;
		else if (r < 12)
			frame_buf[FRAME_LEN-1] = frame_buf[FRAME_LEN-1] + 8'($urandom_range(255, 1));
		send_frame_buf(0, FRAME_LEN);
	endtask

	// Header with any type byte, cut short at a random point
	task automatic send_broken_frame();
		int k;
		k = $urandom_range(FRAME_LEN - 2);
		frame_buf[0] = HDR_BYTE;
		for (int i = 1; i <= k; i++)
			frame_buf[i] = 8'($urandom);
		send_frame_buf(0, k + 1);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(6, 1);
		for (int i = 0; i < n; i++)
			send_byte(($urandom_range(9) == 0) ? HDR_BYTE : 8'($urandom));
	endtask

	// All three record kinds, axis extremes, header bytes inside the payload
	task automatic test_record_kinds();
		load_frame(TYPE_ACC, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
		send_frame_buf(0, FRAME_LEN);
		load_frame(TYPE_GYR, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h1234);
		send_frame_buf(0, FRAME_LEN);
		load_frame(TYPE_ANG, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF);
		send_frame_buf(0, FRAME_LEN);
		load_frame(TYPE_ACC, 16'h5555, 16'h5555, 16'h5555, 16'h5555);
		send_frame_buf(0, FRAME_LEN);
		drain_records();
	endtask

	// Good frames of in-range types that carry no record, then one gyro frame that does
	task automatic test_unused_types();
		load_frame(TYPE_LO, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
		send_frame_buf(0, FRAME_LEN);
		load_frame(8'h54, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF);
		send_frame_buf(0, FRAME_LEN);
		load_frame(HDR_BYTE, 16'h0102, 16'h0304, 16'h0506, 16'h0708);
		send_frame_buf(0, FRAME_LEN);
		load_frame(TYPE_HI, 16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0);
		send_frame_buf(0, FRAME_LEN);
		load_frame(TYPE_GYR, 16'h0BAD, 16'hCAFE, 16'h0042, 16'h0000);
		send_frame_buf(0, FRAME_LEN);
		drain_records();
	endtask

	// Type bytes just outside the range drop back to hunting
	task automatic test_bad_type();
		send_byte(HDR_BYTE);
		send_byte(TYPE_LO - 8'd1);
		send_byte(HDR_BYTE);
		send_byte(TYPE_HI + 8'd1);
		send_byte(8'h00);
		send_byte(8'hFF);
		load_frame(TYPE_ANG, 16'h4000, 16'hC000, 16'h0080, 16'h0000);
		send_frame_buf(0, FRAME_LEN);
		drain_records();
	endtask

	// Wrong checksum: plain byte drops to hunting, header byte opens the next frame
	task automatic test_bad_checksum();
		load_frame(TYPE_ACC, 16'h0100, 16'h0200, 16'h0300, 16'h0400);
		frame_buf[FRAME_LEN-1] = frame_buf[FRAME_LEN-1] + 8'd1;
		if (frame_buf[FRAME_LEN-1] == HDR_BYTE)
			frame_buf[FRAME_LEN-1] = frame_buf[FRAME_LEN-1] + 8'd1;
		send_frame_buf(0, FRAME_LEN);
		load_frame(TYPE_GYR, 16'h0102, 16'h0304, 16'h0506, 16'h0708);
		if (frame_buf[FRAME_LEN-1] == HDR_BYTE)
			load_frame(TYPE_GYR, 16'h0102, 16'h0304, 16'h0506, 16'h0709);
		frame_buf[FRAME_LEN-1] = HDR_BYTE;
		send_frame_buf(0, FRAME_LEN);
		// the closing header byte stands in for this frame's header
		load_frame(TYPE_ANG, 16'hFEDC, 16'h0123, 16'h7FFF, 16'h0000);
		send_frame_buf(1, FRAME_LEN - 1);
		drain_records();
	endtask

	// Hold the output off long enough to fill the block and stall its input
	task automatic test_backpressure();
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++) begin
			load_frame(TYPE_ACC + 8'(i % 3), rand_word(), rand_word(), rand_word(), rand_word());
			send_frame_buf(0, FRAME_LEN);
		end
		drain_records();
	endtask

	// Mostly good frames, with noise and cut-short frames mixed in
	task automatic test_random_traffic(input int gap, input int stall, input int byte_goal);
		int start_bytes;
		int r;
		gap_pct = gap;
		stall_pct = stall;
		start_bytes = frame_bytes_sent;
		while (frame_bytes_sent - start_bytes < byte_goal) begin
			r = $urandom_range(99);
			if (r < 75)
				send_random_frame();
			else if (r < 88)
				send_noise();
			else
				send_broken_frame();
		end
		drain_records();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_record_kinds();
		test_unused_types();
		test_bad_type();
		test_bad_checksum();
		test_backpressure();
		test_random_traffic(0, 0, PHASE_BYTES);
		test_random_traffic(51, 0, PHASE_BYTES);
		test_random_traffic(0, 51, PHASE_BYTES);
		test_random_traffic(19, 19, PHASE_BYTES);
		repeat (8) @(posedge clk);
		if (pending_records.size() != 0) begin
			error_count += pending_records.size();
			$display("%0t ns: %0d records expected, actual none", $time, pending_records.size());
		end
		if (error_count == 0)
			$display("imu_serial_frame_parser_tb: clean");
		else
			$display("imu_serial_frame_parser_tb: errors");
		$finish;
	end

endmodule

// ===== imu_serial_frame_parser.f =====
hdl/isfp_pkg.sv
hdl/isfp_parser.sv
hdl/isfp_out_skid.sv
hdl/imu_serial_frame_parser.sv
hdl/isfp_checker.sv
dv/imu_serial_frame_parser_tb.sv
